### rtl/core/ntc_pkg.sv
// Shared types, constants and helper functions for the NTC thermistor converter.
// No dependencies; every module of the converter imports this package.
`default_nettype none
package ntc_pkg;

    localparam int ADC_BITS  = 12;
    localparam int FULL      = (1 << ADC_BITS) - 1;
    localparam int EXP_W     = $clog2(ADC_BITS);
    localparam int M_W       = 31;
    localparam int SH_W      = $clog2(M_W);
    localparam int FRAC_BITS = 24;
    localparam int LOG_W     = EXP_W + FRAC_BITS;
    localparam int LN2_W     = 30;
    localparam int D_W       = 46;
    localparam int R_W       = D_W - 1;
    localparam int N_W       = 62;
    localparam int Q_W       = 22;
    localparam int T_W       = 24;
    localparam int RECIP_SH  = 27;
    localparam int V_W       = T_W - RECIP_SH + 21;
    localparam int TEMP_W    = 15;

    localparam logic [LN2_W-1:0] LN2_Q30     = LN2_W'(744261118);
    localparam logic [N_W-1:0]   NUM_C       = N_W'(64'd188430800000 << 24);
    localparam logic [D_W-1:0]   D_BASE      = D_W'(64'd395000 << 24);
    localparam logic [15:0]      T0_SCALED   = 16'd29815;
    localparam logic [T_W-1:0]   KELVIN_OFS  = T_W'(437040);
    localparam logic [20:0]      RECIP_100   = 21'd1342177;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN     = -15'sd4371;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX     = 15'sd15999;
    localparam logic signed [TEMP_W-1:0] TEMP_ZERO    = -15'sd1584;
    localparam logic signed [TEMP_W-1:0] TEMP_FULL    = -15'sd4370;
    localparam logic signed [TEMP_W-1:0] TEMP_CORRUPT = 15'sd15998;

    localparam logic signed [TEMP_W-1:0] LOW_RESET  = -15'sd640;
    localparam logic signed [TEMP_W-1:0] HIGH_RESET = 15'sd2000;

    typedef enum logic [1:0] {
        REG_LOW_LIMIT  = 2'd0,
        REG_HIGH_LIMIT = 2'd1,
        REG_CORRUPT    = 2'd2,
        REG_NONE       = 2'd3
    } ntc_reg_t;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             full;
        logic             nonpos;
        logic [EXP_W-1:0] exp_a;
        logic [EXP_W-1:0] exp_b;
    } ntc_side_t;

    function automatic logic [EXP_W-1:0] lead_one(input logic [ADC_BITS-1:0] n);
        logic [EXP_W-1:0] e;
        e = '0;
        for (int i = 0; i < ADC_BITS; i++) begin
            if (n[i]) begin
                e = EXP_W'(i);
            end
        end
        return e;
    endfunction

    function automatic logic [M_W-1:0] normalize(input logic [ADC_BITS-1:0] n,
                                                 input logic [EXP_W-1:0] e);
        logic [SH_W-1:0] sh;
        sh = SH_W'(M_W - 1) - SH_W'(e);
        return M_W'(n) << sh;
    endfunction

endpackage
`default_nettype wire

### rtl/core/ntc_adc_to_celsius_checker_top.sv
// Top level of the NTC thermistor ADC-to-Celsius converter with limit check.
// Depends on ntc_pkg, ntc_log_step and ntc_div_step.
`default_nettype none
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid/s_tready    s_tdata[11:0] adc_sample
//  m_        out        m_tvalid/m_tready    m_tdata[14:0] temperature, m_tuser[0] temp_ok
//  cfg_      in         cfg_wr_en            cfg_wr_index, cfg_wr_data
//
// One transaction is accepted per clock cycle while the output is not stalled.
// The pipeline is made up of the 24 log2 squaring stages, the 22 stages of the
// restoring divider and ten arithmetic stages.
// Reset is synchronous and active low; it clears all stage valid bits and loads
// the register reset values. When the output transaction is stalled the whole
// pipeline holds, so nothing is lost or repeated.
module ntc_adc_to_celsius_checker_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,      // [11:0] adc_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,      // [14:0] temperature
    output logic [0:0]       m_tuser,      // [0] temp_ok
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_index,
    input  wire logic [14:0] cfg_wr_data
);
    import ntc_pkg::*;

    // The pipeline advances whenever the output register is empty or being taken.
    logic adv;

    // Configuration registers.
    logic signed [TEMP_W-1:0] low_limit_reg, high_limit_reg;
    logic                     corrupt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_limit_reg  <= LOW_RESET;
            high_limit_reg <= HIGH_RESET;
            corrupt_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (ntc_reg_t'(cfg_wr_index))
                REG_LOW_LIMIT:  low_limit_reg  <= $signed(cfg_wr_data);
                REG_HIGH_LIMIT: high_limit_reg <= $signed(cfg_wr_data);
                REG_CORRUPT:    corrupt_reg    <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Front stage: split the sample into the two resistor-ratio operands
    // (M - s and s), find their top set bits and normalize them to Q30.
    logic [ADC_BITS-1:0] samp, op_a;
    logic [EXP_W-1:0]    ea, eb;
    ntc_side_t           front_next;

    always_comb begin
        samp             = s_tdata[ADC_BITS-1:0];
        op_a             = ADC_BITS'(FULL) - samp;
        ea               = lead_one(op_a);
        eb               = lead_one(samp);
        front_next       = '0;
        front_next.valid = s_tvalid;
        front_next.zero  = (samp == '0);
        front_next.full  = (samp == ADC_BITS'(FULL));
        front_next.exp_a = ea;
        front_next.exp_b = eb;
    end

    ntc_side_t            log_side [0:FRAC_BITS];
    logic [M_W-1:0]       log_ma   [0:FRAC_BITS];
    logic [M_W-1:0]       log_mb   [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] log_fa   [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] log_fb   [0:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_side[0] <= '0;
        end else if (adv) begin
            log_side[0] <= front_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            log_ma[0] <= normalize(op_a, ea);
            log_mb[0] <= normalize(samp, eb);
            log_fa[0] <= '0;
            log_fb[0] <= '0;
        end
    end

    // Log2 fraction: one squaring per stage, one fraction bit per stage.
    for (genvar g = 0; g < FRAC_BITS; g++) begin : g_log
        ntc_log_step u_log_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .side_in  (log_side[g]),
            .ma_in    (log_ma[g]),
            .mb_in    (log_mb[g]),
            .fa_in    (log_fa[g]),
            .fb_in    (log_fb[g]),
            .side_out (log_side[g+1]),
            .ma_out   (log_ma[g+1]),
            .mb_out   (log_mb[g+1]),
            .fa_out   (log_fa[g+1]),
            .fb_out   (log_fb[g+1])
        );
    end

    // Difference of the two logarithms as sign and magnitude.
    logic [LOG_W-1:0] la, lb, mag_next, mag_reg;
    logic             neg_next, neg_reg;
    ntc_side_t        diff_side_reg;

    always_comb begin
        la       = {log_side[FRAC_BITS].exp_a, log_fa[FRAC_BITS]};
        lb       = {log_side[FRAC_BITS].exp_b, log_fb[FRAC_BITS]};
        neg_next = la < lb;
        mag_next = neg_next ? (lb - la) : (la - lb);
    end

    // Scale by ln2 (Q30), rounding half up, then apply the sign.
    logic [LOG_W+LN2_W-1:0]  ln_prod;
    logic [LOG_W-1:0]        ln_mag;
    logic signed [LOG_W:0]   lnr_next, lnr_reg;
    ntc_side_t               ln_side_reg;

    always_comb begin
        ln_prod  = (LOG_W+LN2_W)'(mag_reg) * (LOG_W+LN2_W)'(LN2_Q30)
                 + ((LOG_W+LN2_W)'(1) << (LN2_W - 1));
        ln_mag   = ln_prod[LOG_W+LN2_W-1:LN2_W];
        lnr_next = neg_reg ? -$signed({1'b0, ln_mag}) : $signed({1'b0, ln_mag});
    end

    // T0 * ln(R/R0) term, then the beta-equation denominator.
    logic signed [D_W-1:0] p_next, p_reg, d_next, d_reg;
    ntc_side_t             p_side_reg, d_side_reg;

    always_comb begin
        p_next = D_W'(lnr_reg) * $signed({1'b0, (D_W-1)'(T0_SCALED)});
        d_next = $signed(D_BASE) + p_reg;
    end

    // Divider setup: dividend with half-divisor rounding, first partial remainder.
    logic [R_W-1:0] dmag;
    logic [N_W-1:0] dividend;
    ntc_side_t      prep_side;

    always_comb begin
        dmag             = d_reg[R_W-1:0];
        dividend         = NUM_C + N_W'(dmag >> 1);
        prep_side        = d_side_reg;
        prep_side.nonpos = (d_reg <= 0);
    end

    ntc_side_t      div_side [0:Q_W];
    logic [R_W-1:0] div_d    [0:Q_W];
    logic [R_W-1:0] div_r    [0:Q_W];
    logic [Q_W-1:0] div_n    [0:Q_W];
    logic [Q_W-1:0] div_q    [0:Q_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_side_reg <= '0;
            ln_side_reg   <= '0;
            p_side_reg    <= '0;
            d_side_reg    <= '0;
            div_side[0]   <= '0;
        end else if (adv) begin
            diff_side_reg <= log_side[FRAC_BITS];
            ln_side_reg   <= diff_side_reg;
            p_side_reg    <= ln_side_reg;
            d_side_reg    <= p_side_reg;
            div_side[0]   <= prep_side;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_reg  <= mag_next;
            neg_reg  <= neg_next;
            lnr_reg  <= lnr_next;
            p_reg    <= p_next;
            d_reg    <= d_next;
            div_d[0] <= dmag;
            div_r[0] <= R_W'(dividend[N_W-1:Q_W]);
            div_n[0] <= dividend[Q_W-1:0];
            div_q[0] <= '0;
        end
    end

    // Kelvin quotient: one bit per stage.
    for (genvar g = 0; g < Q_W; g++) begin : g_div
        ntc_div_step u_div_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .side_in  (div_side[g]),
            .d_in     (div_d[g]),
            .r_in     (div_r[g]),
            .n_in     (div_n[g]),
            .q_in     (div_q[g]),
            .side_out (div_side[g+1]),
            .d_out    (div_d[g+1]),
            .r_out    (div_r[g+1]),
            .n_out    (div_n[g+1]),
            .q_out    (div_q[g+1])
        );
    end

    // Celsius in 1/1600 units, then magnitude plus half of the divisor of 100.
    logic signed [T_W-1:0] w;
    logic [T_W-1:0]        t_next, t_reg, t2_reg;
    logic                  wneg_next, wneg_reg, wneg2_reg, wneg3_reg;
    ntc_side_t             w_side_reg, r_side_reg, f_side_reg;

    always_comb begin
        w         = $signed(T_W'(div_q[Q_W])) - $signed(KELVIN_OFS);
        wneg_next = w[T_W-1];
        t_next    = (wneg_next ? T_W'(-w) : T_W'(w)) + T_W'(50);
    end

    // Divide by 100 through the reciprocal; the estimate is at most one low.
    logic [T_W+20:0]  rp;
    logic [V_W-1:0]   q0_next, q0_reg;
    logic [T_W:0]     rem;
    logic [V_W-1:0]   vmag_next, vmag_reg;

    always_comb begin
        rp        = (T_W+21)'(t_reg) * (T_W+21)'(RECIP_100);
        q0_next   = rp[T_W+20:RECIP_SH];
        rem       = (T_W+1)'(t2_reg) - (T_W+1)'(q0_reg) * (T_W+1)'(100);
        vmag_next = q0_reg + V_W'(rem >= (T_W+1)'(100));
    end

    // Sign, saturation, special cases, corrupt mode and the limit test.
    logic signed [V_W:0]      v;
    logic signed [TEMP_W-1:0] temp_next, temp_reg;
    logic                     dv_next, dv_reg, out_valid_reg;

    always_comb begin
        v = wneg3_reg ? -$signed({1'b0, vmag_reg}) : $signed({1'b0, vmag_reg});
        if (v > (V_W+1)'(TEMP_MAX)) begin
            temp_next = TEMP_MAX;
        end else if (v < (V_W+1)'(TEMP_MIN)) begin
            temp_next = TEMP_MIN;
        end else begin
            temp_next = TEMP_W'(v);
        end
        if (f_side_reg.zero) begin
            temp_next = TEMP_ZERO;
        end else if (f_side_reg.full) begin
            temp_next = TEMP_FULL;
        end else if (f_side_reg.nonpos) begin
            temp_next = TEMP_MAX;
        end
        dv_next = (temp_next > low_limit_reg) && (temp_next < high_limit_reg);
        if (corrupt_reg) begin
            temp_next = TEMP_CORRUPT;
            dv_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_side_reg    <= '0;
            r_side_reg    <= '0;
            f_side_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            w_side_reg    <= div_side[Q_W];
            r_side_reg    <= w_side_reg;
            f_side_reg    <= r_side_reg;
            out_valid_reg <= f_side_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_reg     <= t_next;
            wneg_reg  <= wneg_next;
            q0_reg    <= q0_next;
            t2_reg    <= t_reg;
            wneg2_reg <= wneg_reg;
            vmag_reg  <= vmag_next;
            wneg3_reg <= wneg2_reg;
            temp_reg  <= temp_next;
            dv_reg    <= dv_next;
        end
    end

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, temp_reg};
    assign m_tuser  = dv_reg;

    // The input is taken exactly when the output register can move.
    a_ready_follows_output: assert property (@(posedge aclk)
        s_tready == (!out_valid_reg || m_tready))
        else $error("input ready does not follow the output register state");

    // An accepted transaction appears in the first stage on the next edge.
    a_front_captures: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> log_side[0].valid)
        else $error("accepted transaction missing from the front stage");

    // While stalled, the divider output stage holds its valid bit.
    a_stall_holds_div: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(div_side[Q_W].valid))
        else $error("pipeline moved during a stall");

    // Every delivered temperature lies in the saturated range.
    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (temp_reg >= TEMP_MIN) && (temp_reg <= TEMP_MAX))
        else $error("temperature outside the saturated range");

    // A result flagged valid never comes from corrupt mode.
    a_corrupt_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && dv_reg |-> temp_reg != TEMP_CORRUPT || high_limit_reg > TEMP_CORRUPT)
        else $error("corrupt result flagged valid");

endmodule
`default_nettype wire

### rtl/core/ntc_log_step.sv
// One squaring step of the log2 fraction for both divider operands.
// Depends on ntc_pkg.
`default_nettype none
module ntc_log_step (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire ntc_pkg::ntc_side_t          side_in,
    input  wire logic [ntc_pkg::M_W-1:0]     ma_in,
    input  wire logic [ntc_pkg::M_W-1:0]     mb_in,
    input  wire logic [ntc_pkg::FRAC_BITS-1:0] fa_in,
    input  wire logic [ntc_pkg::FRAC_BITS-1:0] fb_in,
    output ntc_pkg::ntc_side_t               side_out,
    output logic [ntc_pkg::M_W-1:0]          ma_out,
    output logic [ntc_pkg::M_W-1:0]          mb_out,
    output logic [ntc_pkg::FRAC_BITS-1:0]    fa_out,
    output logic [ntc_pkg::FRAC_BITS-1:0]    fb_out
);
    import ntc_pkg::*;

    logic [2*M_W-1:0]     sq_a, sq_b;
    logic [M_W:0]         t_a, t_b;
    ntc_side_t            side_reg;
    logic [M_W-1:0]       ma_reg, mb_reg, ma_next, mb_next;
    logic [FRAC_BITS-1:0] fa_reg, fb_reg, fa_next, fb_next;

    // Square the Q30 mantissa; a result of two or more yields a fraction bit of one.
    always_comb begin
        sq_a    = {{M_W{1'b0}}, ma_in} * {{M_W{1'b0}}, ma_in};
        sq_b    = {{M_W{1'b0}}, mb_in} * {{M_W{1'b0}}, mb_in};
        t_a     = sq_a[2*M_W-1:M_W-1];
        t_b     = sq_b[2*M_W-1:M_W-1];
        ma_next = t_a[M_W] ? t_a[M_W:1] : t_a[M_W-1:0];
        mb_next = t_b[M_W] ? t_b[M_W:1] : t_b[M_W-1:0];
        fa_next = {fa_in[FRAC_BITS-2:0], t_a[M_W]};
        fb_next = {fb_in[FRAC_BITS-2:0], t_b[M_W]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= '0;
        end else if (en) begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg <= ma_next;
            mb_reg <= mb_next;
            fa_reg <= fa_next;
            fb_reg <= fb_next;
        end
    end

    assign side_out = side_reg;
    assign ma_out   = ma_reg;
    assign mb_out   = mb_reg;
    assign fa_out   = fa_reg;
    assign fb_out   = fb_reg;

endmodule
`default_nettype wire

### rtl/core/ntc_div_step.sv
// One restoring step of the Kelvin divider: one quotient bit per stage.
// Depends on ntc_pkg.
`default_nettype none
module ntc_div_step (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire ntc_pkg::ntc_side_t      side_in,
    input  wire logic [ntc_pkg::R_W-1:0] d_in,
    input  wire logic [ntc_pkg::R_W-1:0] r_in,
    input  wire logic [ntc_pkg::Q_W-1:0] n_in,
    input  wire logic [ntc_pkg::Q_W-1:0] q_in,
    output ntc_pkg::ntc_side_t           side_out,
    output logic [ntc_pkg::R_W-1:0]      d_out,
    output logic [ntc_pkg::R_W-1:0]      r_out,
    output logic [ntc_pkg::Q_W-1:0]      n_out,
    output logic [ntc_pkg::Q_W-1:0]      q_out
);
    import ntc_pkg::*;

    logic [R_W:0]   rs, diff;
    logic           ge;
    ntc_side_t      side_reg;
    logic [R_W-1:0] d_reg, r_reg, r_next;
    logic [Q_W-1:0] n_reg, q_reg;

    always_comb begin
        rs     = {r_in, n_in[Q_W-1]};
        ge     = rs >= {1'b0, d_in};
        diff   = rs - {1'b0, d_in};
        r_next = ge ? diff[R_W-1:0] : rs[R_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= '0;
        end else if (en) begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_in;
            r_reg <= r_next;
            n_reg <= {n_in[Q_W-2:0], 1'b0};
            q_reg <= {q_in[Q_W-2:0], ge};
        end
    end

    assign side_out = side_reg;
    assign d_out    = d_reg;
    assign r_out    = r_reg;
    assign n_out    = n_reg;
    assign q_out    = q_reg;

endmodule
`default_nettype wire

### verif/tb_ntc_adc_to_celsius_checker_top.sv
// Self-checking testbench for the NTC thermistor ADC-to-Celsius converter.
// Depends on ntc_pkg and the converter RTL; all prediction is done locally.
module tb_ntc_adc_to_celsius_checker_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ntc_pkg::*;

    localparam int LATENCY    = 56;
    localparam int WDOG_LIMIT = 20000;
    localparam int NUM_RANDOM = 1680;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     temp_ok;
    } reading_t;

    // One row of the directed table: a sample and, where it is obvious, the
    // typed-in answer under the current register settings.
    typedef struct {
        logic [11:0] sample;
        logic        known;
        reading_t    answer;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_index = '0;
    logic [14:0] cfg_wr_data = '0;

    // Local copy of the register file, used by the predictor.
    logic signed [TEMP_W-1:0] low_bound;
    logic signed [TEMP_W-1:0] high_bound;
    logic                     fault_forced;

    reading_t pending_readings[$];
    int       fail_count = 0;
    int       results_seen = 0;
    int       samples_sent = 0;
    int       idle_cycles = 0;
    bit       stall_enable = 1'b0;
    bit       hold_off = 1'b0;
    bit       timed_out = 1'b0;

    ntc_adc_to_celsius_checker_top dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // log2 of a positive integer in Q24: integer part from the top set bit,
    // fraction from repeated squaring of a Q30 mantissa with truncation.
    function automatic logic [63:0] log2_fixed(input int unsigned n);
        int unsigned  e;
        logic [63:0]  mant;
        logic [63:0]  frac;
        e = 0;
        while (e < 31 && (n >> (e + 1)) != 0) e++;
        mant = 64'(n) << (30 - e);
        frac = '0;
        for (int i = 0; i < 24; i++) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= (64'd2 << 30)) begin
                mant = mant >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(e) << 24) | frac;
    endfunction

    // Thermistor sample to Celsius in 1/16 degree, saturated.
    function automatic logic signed [TEMP_W-1:0] celsius_of(input logic [11:0] s);
        logic [63:0]        la, lb, mag, num, q;
        logic signed [63:0] lnr, den, w, v;
        bit                 neg;
        if (s == 0) return -15'sd1584;
        if (s == 12'hFFF) return -15'sd4370;
        la = log2_fixed(4095 - s);
        lb = log2_fixed(s);
        neg = la < lb;
        mag = neg ? lb - la : la - lb;
        mag = (mag * 64'd744261118 + (64'd1 << 29)) >> 30;
        lnr = neg ? -$signed(mag) : $signed(mag);
        den = 64'sd395000 * (64'sd1 << 24) + 64'sd29815 * lnr;
        if (den <= 0) return 15'sd15999;
        num = 64'd1600 * 64'd3950 * 64'd29815 * (64'd1 << 24);
        q = (num + 64'(den) / 2) / 64'(den);
        w = $signed(q) - 64'sd437040;
        if (w >= 0) v = (w + 50) / 100;
        else v = -((-w + 50) / 100);
        if (v > 15999) v = 15999;
        if (v < -4371) v = -4371;
        return TEMP_W'(v);
    endfunction

    function automatic reading_t predict_reading(input logic [11:0] s);
        reading_t r;
        if (fault_forced) begin
            r.temperature = 15'sd15998;
            r.temp_ok = 1'b0;
        end else begin
            r.temperature = celsius_of(s);
            r.temp_ok = (r.temperature > low_bound) && (r.temperature < high_bound);
        end
        return r;
    endfunction

    // Register writes happen only while the pipeline is empty.
    task automatic write_reg(input ntc_reg_t idx, input logic [14:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_LOW_LIMIT:  low_bound = value;
            REG_HIGH_LIMIT: high_bound = value;
            REG_CORRUPT:    fault_forced = value[0];
            default: ;
        endcase
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        wait (pending_readings.size() == 0 || timed_out);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // Offers one sample and waits for its transaction; the prediction is queued
    // at the accepting edge so it lines up with the in-order result stream.
    // The valid stays high after acceptance so the next sample can follow
    // without a gap; whoever stops sending drops it.
    task automatic send_sample(input logic [11:0] s, input logic known,
                               input reading_t answer);
        reading_t r;
        while (stall_enable && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, s};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_reading(s);
        if (known && r !== answer) begin
            $error("table row %0d: predictor %p disagrees with typed %p", s, r, answer);
            fail_count++;
        end
        pending_readings.push_back(known ? answer : r);
        samples_sent++;
    endtask

    // Result side: random back-pressure plus an optional long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !hold_off && !(stall_enable && $urandom_range(99) < 36);
    end

    // Checker: compares each result transaction with the oldest prediction.
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_readings.size() == 0) begin
                $error("result with nothing expected: temperature=%0d",
                       $signed(m_tdata[14:0]));
                fail_count++;
            end else begin
                want = pending_readings.pop_front();
                if (m_tdata[14:0] !== want.temperature) begin
                    $error("temperature: expected %0d, actual %0d",
                           want.temperature, $signed(m_tdata[14:0]));
                    fail_count++;
                end
                if (m_tuser[0] !== want.temp_ok) begin
                    $error("temp_ok: expected %0b, actual %0b",
                           want.temp_ok, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles in a row with no transaction on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d results outstanding",
                     pending_readings.size());
            $display("[ntc_adc_to_celsius_checker_top] ERROR");
            $finish;
        end
    end

    function automatic reading_t fixed(input int t, input bit v);
        reading_t r;
        r.temperature = TEMP_W'(t);
        r.temp_ok = v;
        return r;
    endfunction

    function automatic row_t mk_row(input logic [11:0] s, input bit k, input reading_t a);
        row_t r;
        r.sample = s;
        r.known = k;
        r.answer = a;
        return r;
    endfunction

    initial begin
        row_t         table_rows[$];
        logic [11:0]  s;
        logic [14:0]  lo, hi;

        low_bound = LOW_RESET;
        high_bound = HIGH_RESET;
        fault_forced = 1'b0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under reset registers: zero and full-scale samples,
        // single-bit and alternating patterns, mid-scale near room temperature.
        table_rows.push_back(mk_row(12'h000, 1, fixed(-1584, 0)));
        table_rows.push_back(mk_row(12'hFFF, 1, fixed(-4370, 0)));
        table_rows.push_back(mk_row(12'h001, 0, '0));
        table_rows.push_back(mk_row(12'hFFE, 0, '0));
        table_rows.push_back(mk_row(12'h7FF, 0, '0));
        table_rows.push_back(mk_row(12'h800, 0, '0));
        table_rows.push_back(mk_row(12'h555, 0, '0));
        table_rows.push_back(mk_row(12'hAAA, 0, '0));
        table_rows.push_back(mk_row(12'h002, 0, '0));
        table_rows.push_back(mk_row(12'h010, 0, '0));
        table_rows.push_back(mk_row(12'h100, 0, '0));
        table_rows.push_back(mk_row(12'hF00, 0, '0));
        foreach (table_rows[i])
            send_sample(table_rows[i].sample, table_rows[i].known, table_rows[i].answer);
        drain_pipeline();

        // Widest limits: both special samples fall strictly inside.
        write_reg(REG_LOW_LIMIT, -15'sd4371);
        write_reg(REG_HIGH_LIMIT, 15'sd15999);
        send_sample(12'h000, 1, fixed(-1584, 1));
        send_sample(12'hFFF, 1, fixed(-4370, 1));
        send_sample(12'h001, 0, '0);
        // An out-of-range index must leave every register untouched.
        drain_pipeline();
        write_reg(REG_NONE, 15'h1234);
        send_sample(12'h000, 1, fixed(-1584, 1));
        drain_pipeline();

        // Corrupt mode forces the fault reading whatever the sample.
        write_reg(REG_CORRUPT, 15'd1);
        send_sample(12'h000, 1, fixed(15998, 0));
        send_sample(12'hFFF, 1, fixed(15998, 0));
        send_sample(12'h7FF, 1, fixed(15998, 0));
        drain_pipeline();
        write_reg(REG_CORRUPT, 15'd0);

        // Random part in phases, each with its own limits; phases 3 and 4 change the traffic pattern.
        stall_enable = 1'b1;
        for (int phase = 0; phase < 8; phase++) begin
            drain_pipeline();
            case (phase)
                0: begin lo = -15'sd4371; hi = 15'sd15999; end
                1: begin lo = 15'sd15999; hi = -15'sd4371; end
                2: begin lo = LOW_RESET;  hi = HIGH_RESET; end
                default: begin
                    lo = TEMP_W'($urandom_range(20370) - 4371);
                    hi = TEMP_W'($urandom_range(20370) - 4371);
                end
            endcase
            write_reg(REG_LOW_LIMIT, lo);
            write_reg(REG_HIGH_LIMIT, hi);
            write_reg(REG_CORRUPT, (phase == 5) ? 15'd1 : 15'd0);
            // One phase runs with no random stalls on either side.
            stall_enable = (phase != 3);
            if (phase == 4) begin
                // Long receiver hold-off while the sender keeps offering.
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < NUM_RANDOM / 8; n++) begin
                case ($urandom_range(9))
                    0: s = 12'h000;
                    1: s = 12'hFFF;
                    2: s = 12'(4095 - $urandom_range(15));
                    3: s = 12'($urandom_range(15));
                    default: s = 12'($urandom);
                endcase
                send_sample(s, 0, '0);
                // Once per phase the sender waits out every outstanding result.
                if (n == 100) begin
                    s_tvalid <= 1'b0;
                    wait (pending_readings.size() == 0);
                end
            end
        end
        stall_enable = 1'b0;

        s_tvalid <= 1'b0;
        wait (pending_readings.size() == 0);
        repeat (LATENCY + 4) @(posedge aclk);

        $display("Sent %0d samples and checked %0d results over eight register settings,",
                 samples_sent, results_seen);
        $display("including corrupt mode, extreme limits and long output back-pressure.");
        if (fail_count == 0 && pending_readings.size() == 0)
            $display("[ntc_adc_to_celsius_checker_top] OK");
        else
            $display("[ntc_adc_to_celsius_checker_top] ERROR");
        $finish;
    end
endmodule
